FILE: hw/rtl/knn_pkg.sv
// knn_pkg: shared widths, register indexes, reset values and the candidate
// record passed from the distance front end to the list back end.
// No dependencies.
package knn_pkg;

    localparam int DIST_W    = 37;
    localparam int ID_W      = 16;
    localparam int LEN_W     = 5;
    localparam int SLOT_W    = 4;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 1'd1;

    localparam logic [LEN_W-1:0]  LIST_LEN_RST = 5'd11;
    localparam logic [DIST_W-1:0] MAX_DIST_RST = 37'd1000000;
    localparam logic [DIST_W-1:0] DIST_MAX     = {DIST_W{1'b1}};

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [ID_W-1:0]   id;
        logic              last_cand;
    } cand_t;

endpackage

FILE: hw/rtl/knn_front.sv
// knn_front: request intake, squared difference and saturating distance
// accumulation; finished candidates are pushed to the candidate queue.
// Depends on knn_pkg.
module knn_front import knn_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_query_coord,
    input  logic [COORD_BITS-1:0] s_cand_coord,
    input  logic [ID_W-1:0]       s_cand_id,
    input  logic                  s_last_coord,
    input  logic                  s_last_cand,
    output logic                  q_push,
    output cand_t                 q_data,
    input  logic                  q_full
);

    localparam int AD_W  = COORD_BITS + 1;
    localparam int SQ_W  = 2 * AD_W;
    localparam int SUM_W = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;

    logic [AD_W-1:0]   diff;
    logic [AD_W-1:0]   ad;
    logic [SUM_W-1:0]  sum;
    logic [DIST_W-1:0] acc_new;
    logic              adv;

    logic              v1_reg, v2_reg;
    logic [AD_W-1:0]   ad_reg;
    logic [ID_W-1:0]   id1_reg, id2_reg;
    logic              lc1_reg, lc2_reg, lk1_reg, lk2_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [DIST_W-1:0] acc_reg;

    assign diff = {s_query_coord[COORD_BITS-1], s_query_coord}
                - {s_cand_coord[COORD_BITS-1], s_cand_coord};
    assign ad   = diff[AD_W-1] ? (~diff + 1'b1) : diff;

    assign adv     = !(v2_reg && lc2_reg && q_full);
    assign s_ready = adv;

    assign sum     = SUM_W'(acc_reg) + SUM_W'(sq_reg);
    assign acc_new = (sum > SUM_W'(DIST_MAX)) ? DIST_MAX : sum[DIST_W-1:0];

    assign q_push           = v2_reg && lc2_reg && adv;
    assign q_data.dist_sq   = acc_new;
    assign q_data.id        = id2_reg;
    assign q_data.last_cand = lk2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            acc_reg <= '0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                acc_reg <= lc2_reg ? '0 : acc_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ad_reg  <= ad;
            id1_reg <= s_cand_id;
            lc1_reg <= s_last_coord;
            lk1_reg <= s_last_cand;
            sq_reg  <= SQ_W'(ad_reg) * SQ_W'(ad_reg);
            id2_reg <= id1_reg;
            lc2_reg <= lc1_reg;
            lk2_reg <= lk1_reg;
        end
    end

endmodule

FILE: hw/rtl/knn_queue.sv
// knn_queue: short register queue of finished candidates between the front
// end and the list back end.
// Depends on knn_pkg.
module knn_queue import knn_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  cand_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  valid,
    output cand_t pop_data
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    cand_t            entry_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;

    assign full     = (cnt_reg == CNT_W'(Q_DEPTH));
    assign valid    = (cnt_reg != '0);
    assign pop_data = entry_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= (wr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop) begin
                rd_reg <= (rd_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/knn_back.sv
// knn_back: sorted neighbour list as a row of compare-and-shift slots,
// candidate insertion, and list emission through the output register.
// Depends on knn_pkg.
module knn_back import knn_pkg::*; #(
    parameter int MAX_LIST = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [LEN_W-1:0]  cfg_len,
    input  logic [DIST_W-1:0] cfg_max_dist,
    input  logic              q_valid,
    input  cand_t             q_data,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_slot,
    output logic [ID_W-1:0]   m_neighbor_id,
    output logic [DIST_W-1:0] m_dist_sq,
    output logic              m_filled,
    output logic              m_last
);

    localparam int CNT_W = $clog2(MAX_LIST + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic BK_IDLE = 1'b0;
    localparam logic BK_EMIT = 1'b1;

    logic              state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  eff_len;
    logic [CMP_W-1:0]  len_ext;

    logic [DIST_W-1:0] dist_reg [MAX_LIST];
    logic [DIST_W-1:0] dist_next [MAX_LIST];
    logic [ID_W-1:0]   id_reg [MAX_LIST];
    logic [ID_W-1:0]   id_next [MAX_LIST];
    logic [MAX_LIST-1:0] valid_reg, valid_next;
    logic [MAX_LIST-1:0] hit, hit_prev;

    logic ins_en, oload, emit_last;

    assign len_ext = CMP_W'(cfg_len);
    always_comb begin
        if (len_ext == '0) begin
            eff_len = CNT_W'(1);
        end else if (len_ext > CMP_W'(MAX_LIST)) begin
            eff_len = CNT_W'(MAX_LIST);
        end else begin
            eff_len = CNT_W'(len_ext);
        end
    end

    assign q_pop     = (state_reg == BK_IDLE) && q_valid;
    assign ins_en    = q_pop && (q_data.dist_sq < cfg_max_dist);
    assign oload     = (state_reg == BK_EMIT) && (!m_valid || m_ready);
    assign emit_last = (cnt_reg == eff_len - CNT_W'(1));

    always_comb begin
        for (int i = 0; i < MAX_LIST; i++) begin
            hit[i] = (CNT_W'(i) < eff_len)
                  && (!valid_reg[i] || (q_data.dist_sq < dist_reg[i]));
        end
    end
    assign hit_prev = {hit[MAX_LIST-2:0], 1'b0};

    always_comb begin
        valid_next = valid_reg;
        dist_next  = dist_reg;
        id_next    = id_reg;
        if (ins_en) begin
            for (int i = 0; i < MAX_LIST; i++) begin
                if (hit[i]) begin
                    valid_next[i] = 1'b1;
                    if (hit_prev[i]) begin
                        valid_next[i] = valid_reg[(i == 0) ? 0 : i - 1];
                        dist_next[i]  = dist_reg[(i == 0) ? 0 : i - 1];
                        id_next[i]    = id_reg[(i == 0) ? 0 : i - 1];
                    end else begin
                        dist_next[i]  = q_data.dist_sq;
                        id_next[i]    = q_data.id;
                    end
                end
            end
        end else if (oload) begin
            if (emit_last) begin
                valid_next = '0;
            end else begin
                for (int i = 0; i < MAX_LIST; i++) begin
                    if (i == MAX_LIST - 1) begin
                        valid_next[i] = 1'b0;
                    end else begin
                        valid_next[i] = valid_reg[(i == MAX_LIST - 1) ? i : i + 1];
                        dist_next[i]  = dist_reg[(i == MAX_LIST - 1) ? i : i + 1];
                        id_next[i]    = id_reg[(i == MAX_LIST - 1) ? i : i + 1];
                    end
                end
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_pop && q_data.last_cand) begin
                    state_next = BK_EMIT;
                    cnt_next   = '0;
                end
            end
            BK_EMIT: begin
                if (oload) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (emit_last) begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            cnt_reg   <= '0;
            valid_reg <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
            if (oload) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        id_reg   <= id_next;
        if (oload) begin
            m_slot        <= SLOT_W'(cnt_reg);
            m_neighbor_id <= valid_reg[0] ? id_reg[0] : '0;
            m_dist_sq     <= valid_reg[0] ? dist_reg[0] : '0;
            m_filled      <= valid_reg[0];
            m_last        <= emit_last;
        end
    end

    // occupied slots always form a prefix of the list
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_reg + 1'b1) & valid_reg) == '0)
        else $error("list has a gap");

    a_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (oload && emit_last) |=> (valid_reg == '0))
        else $error("list not cleared after emission");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_EMIT) |-> (cnt_reg < eff_len))
        else $error("emission count beyond list length");

    a_no_pop_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_data.last_cand) |=> (state_reg == BK_EMIT && !q_pop))
        else $error("queue popped during emission");

endmodule

FILE: hw/rtl/knn_distance_topk_list.sv
// knn_distance_topk_list: top level, configuration registers, front end,
// candidate queue and list back end.
// Depends on knn_pkg, knn_front, knn_queue, knn_back.
//
// Brute-force k-nearest-neighbour list for one query. The front end takes one
// coordinate request per cycle while s_ready is high; its absolute-difference
// and square registers feed the accumulator. The back end inserts each popped
// candidate under the distance bound into the sorted slot row. A last_coord and
// last_cand request also starts emission of list_len results (zero read as one,
// at most MAX_LIST), one per cycle while m_ready is high, via an output register,
// once that candidate leaves the queue. During emission the two-entry candidate
// queue absorbs finished candidates; once it is full and a further candidate
// finishes, s_ready drops until the back end pops the queue after emission ends.
// Configuration writes are taken every cycle and must only be made when idle.
module knn_distance_topk_list import knn_pkg::*; #(
    parameter int MAX_LIST   = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DIST_W-1:0]     cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COORD_BITS-1:0] s_query_coord,
    input  logic [COORD_BITS-1:0] s_cand_coord,
    input  logic [ID_W-1:0]       s_cand_id,
    input  logic                  s_last_coord,
    input  logic                  s_last_cand,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SLOT_W-1:0]     m_slot,
    output logic [ID_W-1:0]       m_neighbor_id,
    output logic [DIST_W-1:0]     m_dist_sq,
    output logic                  m_filled,
    output logic                  m_last
);

    logic [LEN_W-1:0]  list_len_reg;
    logic [DIST_W-1:0] max_dist_reg;

    logic  q_push, q_full, q_pop, q_valid;
    cand_t q_in, q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            list_len_reg <= LIST_LEN_RST;
            max_dist_reg <= MAX_DIST_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LIST_LEN: list_len_reg <= cfg_data[LEN_W-1:0];
                CFG_MAX_DIST: max_dist_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    knn_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_query_coord (s_query_coord),
        .s_cand_coord  (s_cand_coord),
        .s_cand_id     (s_cand_id),
        .s_last_coord  (s_last_coord),
        .s_last_cand   (s_last_cand),
        .q_push        (q_push),
        .q_data        (q_in),
        .q_full        (q_full)
    );

    knn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    knn_back #(
        .MAX_LIST (MAX_LIST)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_len       (list_len_reg),
        .cfg_max_dist  (max_dist_reg),
        .q_valid       (q_valid),
        .q_data        (q_out),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_neighbor_id (m_neighbor_id),
        .m_dist_sq     (m_dist_sq),
        .m_filled      (m_filled),
        .m_last        (m_last)
    );

endmodule

FILE: verif/knn_distance_topk_list_test.sv
`timescale 1ns / 1ps
// knn_distance_topk_list_test: self-checking bench for the k-nearest list block,
// with a clocked driver, a clocked monitor and a bit-exact predictor of the list.
// Depends on knn_pkg and knn_distance_topk_list.
module knn_distance_topk_list_test;
    import knn_pkg::*;

    localparam int MAX_LIST = 16;

    typedef struct packed {
        logic [15:0] q;
        logic [15:0] c;
        logic [15:0] id;
        logic        lc;
        logic        lk;
    } coord_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] dist_sq;
        logic              filled;
        logic              last;
    } slot_rec_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIST_W-1:0]    cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [15:0]          s_query_coord = '0;
    logic [15:0]          s_cand_coord = '0;
    logic [ID_W-1:0]      s_cand_id = '0;
    logic                 s_last_coord = 1'b0;
    logic                 s_last_cand = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SLOT_W-1:0]    m_slot;
    logic [ID_W-1:0]      m_neighbor_id;
    logic [DIST_W-1:0]    m_dist_sq;
    logic                 m_filled;
    logic                 m_last;

    // predictor state
    logic [LEN_W-1:0]  len_reg = LIST_LEN_RST;
    logic [DIST_W-1:0] bound = MAX_DIST_RST;
    logic [DIST_W-1:0] acc = '0;
    logic [DIST_W-1:0] rank_dist [MAX_LIST] = '{default: '0};
    logic [ID_W-1:0]   rank_id [MAX_LIST] = '{default: '0};
    logic              rank_used [MAX_LIST] = '{default: 1'b0};

    coord_req_t req_queue [$];
    slot_rec_t  due_slots [$];

    int idle_pct = 0;
    int send_gap = 0;
    int stall_cnt = 0;
    int errors = 0;
    int pushed = 0;
    int accepted = 0;
    int checked = 0;
    int lists = 0;

    knn_distance_topk_list DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_query_coord (s_query_coord),
        .s_cand_coord  (s_cand_coord),
        .s_cand_id     (s_cand_id),
        .s_last_coord  (s_last_coord),
        .s_last_cand   (s_last_cand),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot        (m_slot),
        .m_neighbor_id (m_neighbor_id),
        .m_dist_sq     (m_dist_sq),
        .m_filled      (m_filled),
        .m_last        (m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int active_len();
        int n;
        n = len_reg;
        if (n == 0) n = 1;
        if (n > MAX_LIST) n = MAX_LIST;
        return n;
    endfunction

    function automatic void track_request(coord_req_t r);
        longint qv;
        longint cv;
        longint diff;
        logic [63:0] sq;
        logic [63:0] room;
        int n;
        int pos;
        int m;
        slot_rec_t rec;
        qv = $signed(r.q);
        cv = $signed(r.c);
        diff = qv - cv;
        if (diff < 0) diff = -diff;
        sq = diff * diff;
        room = {27'd0, DIST_MAX} - {27'd0, acc};
        if (sq > room) acc = DIST_MAX;
        else acc = acc + sq[DIST_W-1:0];
        if (!r.lc) return;
        n = active_len();
        if (acc < bound) begin
            pos = 0;
            while (pos < n && rank_used[pos] && !(acc < rank_dist[pos])) pos++;
            if (pos < n) begin
                for (m = n - 1; m > pos; m--) begin
                    rank_dist[m] = rank_dist[m-1];
                    rank_id[m]   = rank_id[m-1];
                    rank_used[m] = rank_used[m-1];
                end
                rank_dist[pos] = acc;
                rank_id[pos]   = r.id;
                rank_used[pos] = 1'b1;
            end
        end
        acc = '0;
        if (!r.lk) return;
        for (m = 0; m < n; m++) begin
            rec.slot    = m[SLOT_W-1:0];
            rec.id      = rank_used[m] ? rank_id[m] : '0;
            rec.dist_sq = rank_used[m] ? rank_dist[m] : '0;
            rec.filled  = rank_used[m];
            rec.last    = (m == n - 1);
            due_slots.push_back(rec);
        end
        for (m = 0; m < MAX_LIST; m++) begin
            rank_dist[m] = '0;
            rank_id[m]   = '0;
            rank_used[m] = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge aclk) begin
        coord_req_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_request({s_query_coord, s_cand_coord, s_cand_id, s_last_coord,
                               s_last_cand});
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (req_queue.size() > 0) begin
                    r = req_queue.pop_front();
                    s_query_coord <= r.q;
                    s_cand_coord  <= r.c;
                    s_cand_id     <= r.id;
                    s_last_coord  <= r.lc;
                    s_last_cand   <= r.lk;
                    s_valid       <= 1'b1;
                    if ($urandom_range(99) < idle_pct) send_gap = $urandom_range(1, 7);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        slot_rec_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_slots.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual slot %0d id %0d dist %0d",
                             $time, m_slot, m_neighbor_id, m_dist_sq);
                    errors++;
                end else begin
                    want = due_slots.pop_front();
                    check_field("slot", want.slot, m_slot);
                    check_field("neighbor_id", want.id, m_neighbor_id);
                    check_field("dist_sq", want.dist_sq, m_dist_sq);
                    check_field("filled", want.filled, m_filled);
                    check_field("last", want.last, m_last);
                    checked++;
                    if (want.last) lists++;
                end
            end
            if (stall_cnt > 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if ($urandom_range(99) < idle_pct) begin
                stall_cnt = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic push_req(logic [15:0] q, logic [15:0] c, logic [15:0] id, logic lc, logic lk);
        coord_req_t r;
        r = {q, c, id, lc, lk};
        req_queue.push_back(r);
        pushed++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIST_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_LIST_LEN) len_reg = val[LEN_W-1:0];
        else bound = val;
    endtask

    task automatic settle();
        while (req_queue.size() > 0 || s_valid) @(posedge aclk);
        while (due_slots.size() > 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    // one query: shared query point, candidates near it, some ties, odd lengths and stray flags
    task automatic add_query(int dims, int ncand, bit finish);
        logic [15:0] qp [9];
        logic [15:0] cp [9];
        logic [15:0] id;
        int nd;
        int cv;
        int j;
        int k;
        for (k = 0; k < 9; k++) begin
            if ($urandom_range(3) == 0) qp[k] = 16'($urandom);
            else qp[k] = 16'(int'($urandom_range(1600)) - 800);
        end
        for (j = 0; j < ncand; j++) begin
            id = 16'($urandom);
            nd = ($urandom_range(9) == 0) ? $urandom_range(1, dims + 1) : dims;
            if (j == 0 || $urandom_range(4) != 0) begin
                for (k = 0; k < 9; k++) begin
                    if ($urandom_range(9) == 0) begin
                        cp[k] = 16'($urandom);
                    end else begin
                        cv = $signed(qp[k]);
                        cv = cv + int'($urandom_range(600)) - 300;
                        if (cv > 32767) cv = 32767;
                        if (cv < -32768) cv = -32768;
                        cp[k] = cv[15:0];
                    end
                end
            end
            for (k = 0; k < nd; k++) begin
                if (k == nd - 1) push_req(qp[k], cp[k], id, 1'b1, finish && (j == ncand - 1));
                else push_req(qp[k], cp[k], id, 1'b0, $urandom_range(9) == 0);
            end
        end
    endtask

    initial begin
        logic [DIST_W-1:0] b;
        int p;
        int k;
        int start;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: ties, stray last_cand, bound edge, extreme coords, empty slots
        idle_pct = 25;
        push_req(3, 0, 5, 1'b0, 1'b0);
        push_req(0, 4, 5, 1'b1, 1'b0);
        push_req(-16'd3, 0, 7, 1'b0, 1'b0);
        push_req(0, -16'd4, 7, 1'b1, 1'b0);
        push_req(0, 0, 9, 1'b0, 1'b1);
        push_req(0, 0, 9, 1'b1, 1'b0);
        push_req(16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0);
        push_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        push_req(16'h7FFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
        push_req(16'h8000, 16'h8000, 16'h8000, 1'b1, 1'b0);
        push_req(1000, 0, 16'h00FF, 1'b0, 1'b0);
        push_req(0, 0, 16'h00FF, 1'b1, 1'b0);
        push_req(999, 0, 16'hFF00, 1'b0, 1'b0);
        push_req(0, 44, 16'hFF00, 1'b1, 1'b0);
        push_req(1, 0, 0, 1'b0, 1'b0);
        push_req(0, 1, 0, 1'b1, 1'b1);
        settle();

        // zero length acts as one
        write_reg(CFG_LIST_LEN, {32'($urandom), 5'd0});
        write_reg(CFG_MAX_DIST, DIST_MAX);
        push_req(10, 0, 1, 1'b1, 1'b0);
        push_req(5, 0, 2, 1'b1, 1'b0);
        push_req(5, 0, 3, 1'b1, 1'b1);
        settle();

        // oversize length, zero bound: every slot empty
        write_reg(CFG_LIST_LEN, 37'd31);
        write_reg(CFG_MAX_DIST, '0);
        push_req(0, 0, 4, 1'b1, 1'b0);
        push_req(1, 0, 6, 1'b1, 1'b1);
        settle();

        // accumulator saturation against the full-scale bound
        write_reg(CFG_LIST_LEN, 37'd16);
        write_reg(CFG_MAX_DIST, DIST_MAX);
        for (k = 0; k < 33; k++)
            push_req(16'h8000, 16'h7FFF, 16'h4321, k == 32, 1'b0);
        push_req(5, 2, 16'h5555, 1'b1, 1'b1);
        settle();

        for (p = 0; p < 5; p++) begin
            case (p)
                0: begin
                    idle_pct = 30;
                    write_reg(CFG_LIST_LEN, 37'($urandom_range(2, 15)));
                    write_reg(CFG_MAX_DIST, MAX_DIST_RST);
                end
                1: begin
                    idle_pct = 0;
                    write_reg(CFG_LIST_LEN, 37'd1);
                    write_reg(CFG_MAX_DIST, 37'($urandom_range(1000, 300000)));
                end
                2: begin
                    idle_pct = 50;
                    b = 37'({$urandom, $urandom});
                    write_reg(CFG_LIST_LEN, {32'($urandom), 5'd17});
                    write_reg(CFG_MAX_DIST, b);
                end
                3: begin
                    idle_pct = 30;
                    write_reg(CFG_LIST_LEN, 37'($urandom_range(0, 31)));
                    write_reg(CFG_MAX_DIST, 37'd2000000);
                end
                default: begin
                    idle_pct = 0;
                    write_reg(CFG_LIST_LEN, 37'd16);
                    write_reg(CFG_MAX_DIST, MAX_DIST_RST);
                end
            endcase
            start = pushed;
            while (pushed - start < 4)
                add_query($urandom_range(1, 4), $urandom_range(2, 7), 1'b1);
            // leave a query open so the next settings land mid-query
            if (p < 4 && $urandom_range(1) == 1)
                add_query($urandom_range(1, 4), $urandom_range(1, 3), 1'b0);
            if (p == 4) add_query(2, 3, 1'b1);
            settle();
        end

        $display("Run covered %0d coordinate requests and %0d slot results in %0d lists,",
                 accepted, checked, lists);
        $display("with lengths from zero to oversize, bounds from zero to full scale, ties and saturation.");
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/knn_pkg.sv
hw/rtl/knn_front.sv
hw/rtl/knn_queue.sv
hw/rtl/knn_back.sv
hw/rtl/knn_distance_topk_list.sv
verif/knn_distance_topk_list_test.sv
